### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both use clk_i; ASSERT_CLK also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/bal_pkg.sv
package bal_pkg;

  localparam int unsigned OPC_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LOC_W = 4;
  localparam int unsigned CNT_W = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_SEARCH = 3'd3,
    OP_UPDATE = 3'd4
  } opcode_e;

  typedef logic signed [VAL_W-1:0] word_t;

  localparam word_t POP_EMPTY = '1;

endpackage

### rtl/core/bal_if.sv
interface bal_req_if import bal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  word_t            value;
  logic [LOC_W-1:0] location;

  modport source (output valid, output opcode, output value, output location, input ready);
  modport sink   (input valid, input opcode, input value, input location, output ready);
endinterface

interface bal_rsp_if import bal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  word_t            read_value;
  logic [CNT_W-1:0] count;

  modport source (output valid, output ok, output read_value, output count, input ready);
  modport sink   (input valid, input ok, input read_value, input count, output ready);
endinterface

### rtl/core/bounded_array_list.sv
// Channel | Dir | Modport           | Payload
// req_i   | in  | bal_req_if.sink   | opcode, value, location
// rsp_o   | out | bal_rsp_if.source | ok, read_value, count
//
// One request at a time; the list sits in a single-port-write, registered-read RAM.
// Append, update, rejects, unknown opcodes: exec, then finish; pop: exec, read, finish.
// Search: exec, then one compare per entry (k entries compared, up to count); insert front:
// exec, then one RAM move per cycle from the top entry down, then the front write.
// Reset clears the count and control only; no clearing pass over the RAM.
// A stalled response is held in the output register; the next request is taken meanwhile.
`include "assert_macros.svh"

module bounded_array_list import bal_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  bal_req_if.sink    req_i,
  bal_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_INS0  = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_SRCH  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic             res_ok_q, res_ok_d;
  word_t            res_rv_q, res_rv_d;
  logic [OPC_W-1:0] op_q;
  word_t            val_q;
  logic [LOC_W-1:0] loc_q;

  logic             out_valid_q;
  logic             out_ok_q;
  word_t            out_rv_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic req_fire;
  logic out_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  bal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    res_ok_d  = res_ok_q;
    res_rv_d  = res_rv_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_q;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_ok_d = 1'b0;
        res_rv_d = '0;
        state_d  = S_FIN;
        unique case (op_q)
          OP_APPEND: begin
            if (occ_q < DEPTH_CW) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(occ_q);
              occ_d     = occ_q + CW'(1);
              res_ok_d  = 1'b1;
            end
          end
          OP_INSERT: begin
            if (occ_q < DEPTH_CW) begin
              if (occ_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                occ_d     = occ_q + CW'(1);
                res_ok_d  = 1'b1;
              end else begin
                ram_raddr = AW'(occ_q - CW'(1));
                idx_d     = AW'(occ_q);
                state_d   = S_SHIFT;
              end
            end
          end
          OP_POP: begin
            if (occ_q != '0) begin
              ram_raddr = AW'(occ_q - CW'(1));
              occ_d     = occ_q - CW'(1);
              state_d   = S_POP;
            end else begin
              res_rv_d = POP_EMPTY;
            end
          end
          OP_SEARCH: begin
            if (occ_q != '0) begin
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = S_SRCH;
            end
          end
          OP_UPDATE: begin
            if (32'(loc_q) < 32'(occ_q)) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(loc_q);
              res_ok_d  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        ram_raddr = idx_q - AW'(2);
        if (idx_q == AW'(1)) begin
          state_d = S_INS0;
        end else begin
          idx_d = idx_q - AW'(1);
        end
      end
      S_INS0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        occ_d     = occ_q + CW'(1);
        res_ok_d  = 1'b1;
        state_d   = S_FIN;
      end
      S_POP: begin
        res_rv_d = word_t'(ram_rdata);
        res_ok_d = 1'b1;
        state_d  = S_FIN;
      end
      S_SRCH: begin
        ram_raddr = idx_q + AW'(1);
        if (ram_rdata == val_q) begin
          res_ok_d = 1'b1;
          state_d  = S_FIN;
        end else if ((CW'(idx_q) + CW'(1)) == occ_q) begin
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      res_ok_q    <= 1'b0;
      res_rv_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
      res_ok_q <= res_ok_d;
      res_rv_q <= res_rv_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.opcode;
      val_q <= req_i.value;
      loc_q <= req_i.location;
    end
    if (out_load) begin
      out_ok_q  <= res_ok_q;
      out_rv_q  <= res_rv_q;
      out_cnt_q <= CNT_W'(occ_q);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = out_ok_q;
  assign rsp_o.read_value = out_rv_q;
  assign rsp_o.count      = out_cnt_q;

  `ASSERT_CLK(a_occ_bound, occ_q <= DEPTH_CW, "occupancy above depth")
  `ASSERT_CLK(a_occ_change, (occ_q != $past(occ_q)) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_INS0), "occupancy moved outside exec")
  `ASSERT_CLK(a_we_state, ram_we |-> (state_q == S_EXEC || state_q == S_SHIFT || state_q == S_INS0), "RAM write in wrong state")
  `ASSERT_CLK(a_rsp_src, $rose(out_valid_q) |-> $past(state_q) == S_FIN, "response not from finish")
  `ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> (state_q == S_IDLE && !out_valid_q && occ_q == '0), "not idle in reset")

endmodule

### rtl/core/bal_ram.sv
module bal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
